>>> sv/signed_int_to_decimal_text_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal text block
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_TEXT_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_TEXT_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2D_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/i2d_pkg.sv
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared widths, character codes, types and the shift-add-3 step.
// ----------------------------------------------------------------------------
package i2d_pkg;

	localparam int BIN_W      = 32;
	localparam int DIGITS     = 10;
	localparam int BCD_W      = 4 * DIGITS;
	localparam int DAB_W      = BCD_W + BIN_W;
	localparam int DAB_STAGES = 4;
	localparam int DAB_STEPS  = BIN_W / DAB_STAGES;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	typedef logic [3:0] digit_t;

	// Sign and finished decimal digits of one number.
	typedef struct packed {
		logic             neg;
		logic [BCD_W-1:0] bcd;
	} num_t;

	// One double-dabble iteration: correct every digit of 5 or more, then shift.
	function automatic logic [DAB_W-1:0] dab_step(input logic [DAB_W-1:0] w);
		logic [DAB_W-1:0] r;
		r = w;
		for (int d = 0; d < DIGITS; d++) begin
			if (r[BIN_W+4*d +: 4] >= 4'd5) begin
				r[BIN_W+4*d +: 4] = r[BIN_W+4*d +: 4] + 4'd3;
			end
		end
		return {r[DAB_W-2:0], 1'b0};
	endfunction

endpackage

>>> sv/i2d_dab_stage.sv
// ----------------------------------------------------------------------------
// i2d_dab_stage
// One pipeline stage of the binary to BCD converter, eight iterations deep.
// ----------------------------------------------------------------------------
module i2d_dab_stage (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_neg,
	input  logic [i2d_pkg::DAB_W-1:0] in_word,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     out_neg,
	output logic [i2d_pkg::DAB_W-1:0] out_word
);
	import i2d_pkg::*;

	logic             vld_sn;
	logic             neg_sn;
	logic [DAB_W-1:0] word_sn;
	logic [DAB_W-1:0] word_next;

	always_comb begin
		word_next = in_word;
		for (int s = 0; s < DAB_STEPS; s++) begin
			word_next = dab_step(word_next);
		end
	end

	assign in_ready = !vld_sn || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (in_ready) begin
			vld_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			neg_sn  <= in_neg;
			word_sn <= word_next;
		end
	end

	assign out_valid = vld_sn;
	assign out_neg   = neg_sn;
	assign out_word  = word_sn;

endmodule

>>> sv/i2d_ser.sv
// ----------------------------------------------------------------------------
// i2d_ser
// Sign and ten BCD digits to ASCII characters, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module i2d_ser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          num_valid,
	output logic          num_ready,
	input  i2d_pkg::num_t num,
	output logic          text_valid,
	input  logic          text_stall,
	output logic [7:0]    text_char,
	output logic          last_char
);
	import i2d_pkg::*;

	logic             busy_q;
	logic             neg_q;
	logic [BCD_W-1:0] bcd_q;
	logic [3:0]       idx_q;
	logic             ovld_q;
	logic [7:0]       char_q;
	logic             last_q;

	logic       emit;
	logic       emit_last;
	logic       load;
	logic [3:0] msd;
	logic [7:0] char_next;

	// Position of the most significant nonzero digit; zero shows one digit.
	always_comb begin
		msd = 4'd0;
		for (int d = 0; d < DIGITS; d++) begin
			if (num.bcd[4*d +: 4] != 4'd0) begin
				msd = 4'(d);
			end
		end
	end

	assign emit      = busy_q && (!ovld_q || !text_stall);
	assign emit_last = !neg_q && (idx_q == 4'd0);
	assign num_ready = !busy_q || (emit && emit_last);
	assign load      = num_ready && num_valid;
	assign char_next = neg_q ? CHAR_MINUS : (CHAR_ZERO + {4'd0, bcd_q[4*idx_q +: 4]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && emit_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				ovld_q <= 1'b1;
			end else if (!text_stall) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= num.neg;
			bcd_q <= num.bcd;
			idx_q <= msd;
		end else if (emit) begin
			if (neg_q) begin
				neg_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 4'd1;
			end
		end
		if (emit) begin
			char_q <= char_next;
			last_q <= emit_last;
		end
	end

	assign text_valid = ovld_q;
	assign text_char  = char_q;
	assign last_char  = last_q;

endmodule

>>> sv/signed_int_to_decimal_text_top.sv
// Converts each signed 32-bit value into its decimal ASCII text, most
// significant character first: a leading '-' for negative values, no leading
// zeros, a single '0' for zero, and -2147483648 as its full eleven characters.
// The final character of every number is marked with last_char. The character
// serializer emits the characters of a number one after another and holds on
// text_stall; the conversion pipeline ahead of it keeps further numbers moving
// while it works. A value passes the stage-one register, the double-dabble
// stages, and the serializer's digit and output registers to the output.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text_top
// Signed integer to decimal text converter with valid/stall channels.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     value_valid,
	output logic                     value_stall,
	input  logic signed [i2d_pkg::BIN_W-1:0] value,
	output logic                     text_valid,
	input  logic                     text_stall,
	output logic [7:0]               text_char,
	output logic                     last_char
);
	import i2d_pkg::*;

	// Stage one registers the sign and the magnitude. The magnitude is taken
	// in unsigned arithmetic, so the most negative value yields 2147483648.
	logic             vld_s1;
	logic             neg_s1;
	logic [BIN_W-1:0] mag_s1;
	logic             rdy_s1;

	// Links between the double-dabble stages; link 0 is fed by stage one.
	logic             lnk_valid [DAB_STAGES+1];
	logic             lnk_ready [DAB_STAGES+1];
	logic             lnk_neg   [DAB_STAGES+1];
	logic [DAB_W-1:0] lnk_word  [DAB_STAGES+1];

	num_t ser_num;

	assign rdy_s1      = !vld_s1 || lnk_ready[0];
	assign value_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= value_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && value_valid) begin
			neg_s1 <= value[BIN_W-1];
			mag_s1 <= value[BIN_W-1] ? (BIN_W'(0) - BIN_W'(value)) : BIN_W'(value);
		end
	end

	assign lnk_valid[0] = vld_s1;
	assign lnk_neg[0]   = neg_s1;
	assign lnk_word[0]  = {{BCD_W{1'b0}}, mag_s1};

	// Four equal stages of eight shift-add-3 iterations each build the BCD.
	for (genvar g = 0; g < DAB_STAGES; g++) begin : g_dab
		i2d_dab_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (lnk_valid[g]),
			.in_ready (lnk_ready[g]),
			.in_neg   (lnk_neg[g]),
			.in_word  (lnk_word[g]),
			.out_valid(lnk_valid[g+1]),
			.out_ready(lnk_ready[g+1]),
			.out_neg  (lnk_neg[g+1]),
			.out_word (lnk_word[g+1])
		);
	end

	assign ser_num.neg = lnk_neg[DAB_STAGES];
	assign ser_num.bcd = lnk_word[DAB_STAGES][DAB_W-1:BIN_W];

	// The serializer holds one number and an output register, so a finished
	// character can wait on a stall while the next number is loaded.
	i2d_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (lnk_valid[DAB_STAGES]),
		.num_ready (lnk_ready[DAB_STAGES]),
		.num       (ser_num),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_char (text_char),
		.last_char (last_char)
	);

endmodule

>>> sv/i2d_checker.sv
// ----------------------------------------------------------------------------
// i2d_checker
// Port-level checks for the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_text_top_defines.svh"

module i2d_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     value_valid,
	input logic                     value_stall,
	input logic [i2d_pkg::BIN_W-1:0] value,
	input logic                     text_valid,
	input logic                     text_stall,
	input logic [7:0]               text_char,
	input logic                     last_char
);
	import i2d_pkg::*;

	`I2D_ASSERT_NEXT(a_in_hold, value_valid && value_stall, value_valid && $stable(value), "input changed while stalled")
	`I2D_ASSERT_NEXT(a_out_hold, text_valid && text_stall, text_valid && $stable(text_char) && $stable(last_char), "output changed while stalled")
	`I2D_ASSERT_SAME(a_char_set, text_valid, text_char == CHAR_MINUS || (text_char >= CHAR_ZERO && text_char <= CHAR_ZERO + 8'd9), "character outside the decimal set")
	`I2D_ASSERT_SAME(a_minus_not_last, text_valid && text_char == CHAR_MINUS, !last_char, "minus sign ends a number")
	`I2D_ASSERT_NEXT(a_minus_first, text_valid && !text_stall && !last_char, !(text_valid && text_char == CHAR_MINUS), "minus sign inside a number")

endmodule

bind signed_int_to_decimal_text_top i2d_checker u_i2d_checker (.*);
